@@ rtl/core/itfr_pkg.sv @@
// itfr_pkg: word types and mode codes for the idle-timeout frame receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package itfr_pkg;

  localparam logic [1:0] MODE_RX_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_READ    = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic       frame_done;
    logic [7:0] frame_length;
    logic [7:0] read_data;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/core/idle_timeout_frame_receiver.sv @@
// idle_timeout_frame_receiver: byte framer closed by an idle tick timeout
// the result word passes the read stage and then the output register before it is offered
// throughput: one word per cycle while the input is not stalled; the buffer read lies in the read stage
// the input stalls only while both the read stage and the output register are held
// reset clears length, done, timer and output state; buffer contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module idle_timeout_frame_receiver #(
  parameter int BUF_DEPTH = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire itfr_pkg::in_word_t in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      itfr_pkg::out_word_t out_data_o
);

  import itfr_pkg::*;

  localparam int AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CMP_W = (AW > 8) ? AW : 8;
  localparam logic [AW-1:0] CNT_LAST = AW'(BUF_DEPTH - 1);

  // scalar state
  logic [AW-1:0] count_q, count_d;
  logic          done_q, done_d;
  logic          run_q, run_d;
  logic [15:0]   idle_q, idle_d;
  logic [15:0]   timeout_q;

  // read stage
  logic          s1_valid_q;
  logic          s1_done_q;
  logic [7:0]    s1_len_q;
  logic          s1_hit_q;
  logic          s1_adv;

  // output register
  logic          out_valid_q;
  out_word_t     out_q;

  logic          in_acc;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic [CMP_W-1:0] ridx_ext;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] count_d_ext;
  logic [15:0]   idle_inc;
  logic          rd_hit;

  assign cfg_ready_o = 1'b1;

  assign s1_adv     = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ridx_ext    = CMP_W'(in_data_i.read_index);
  assign count_ext   = CMP_W'(count_q);
  assign count_d_ext = CMP_W'(count_d);
  assign idle_inc    = (idle_q != 16'hffff) ? idle_q + 16'd1 : idle_q;
  assign rd_hit      = (in_data_i.mode == MODE_READ) && (ridx_ext < count_ext);

  always_comb begin
    count_d   = count_q;
    done_d    = done_q;
    run_d     = run_q;
    idle_d    = idle_q;
    mem_we    = 1'b0;
    mem_waddr = count_q;
    if (in_acc) begin
      case (in_data_i.mode)
        MODE_RX_BYTE: begin
          mem_we = 1'b1;
          if (count_q < CNT_LAST) begin
            idle_d  = 16'd0;
            if (count_q == '0) begin
              run_d = 1'b1;
            end
            count_d = count_q + AW'(1);
          end else begin
            // buffer full, restart at position zero
            mem_waddr = '0;
            count_d   = AW'(1);
          end
        end
        MODE_TICK: begin
          if (run_q) begin
            idle_d = idle_inc;
            if (idle_inc >= timeout_q) begin
              done_d = 1'b1;
              run_d  = 1'b0;
            end
          end
        end
        MODE_RESTART: begin
          count_d = '0;
          done_d  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign mem_re    = in_acc && rd_hit;
  assign mem_raddr = ridx_ext[AW-1:0];

  itfr_buf_mem #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_data_i.rx_byte),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      done_q    <= 1'b0;
      run_q     <= 1'b0;
      idle_q    <= '0;
      timeout_q <= TIMEOUT_RESET;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
      run_q   <= run_d;
      idle_q  <= idle_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_done_q <= done_d;
      s1_len_q  <= done_d ? count_d_ext[7:0] : 8'd0;
      s1_hit_q  <= rd_hit;
    end
    if (s1_adv) begin
      out_q.frame_done   <= s1_done_q;
      out_q.frame_length <= s1_len_q;
      out_q.read_data    <= s1_hit_q ? mem_rdata : 8'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_tick_stopped_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.mode == MODE_TICK && !run_q
    |=> idle_q == $past(idle_q) && done_q == $past(done_q))
    else $error("tick changed state while timer stopped");

  a_len_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.frame_done |-> out_data_o.frame_length == 8'd0)
    else $error("frame length reported without done");

  a_byte_clears_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.mode == MODE_RX_BYTE && count_q < CNT_LAST
    |=> idle_q == 16'd0 && count_q == $past(count_q) + AW'(1))
    else $error("byte did not advance the frame");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_LAST)
    else $error("frame length beyond buffer");

  a_read_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |=> out_valid_q)
    else $error("read stage did not reach output register");
`endif

endmodule

`default_nettype wire

@@ rtl/core/itfr_buf_mem.sv @@
// itfr_buf_mem: frame byte store, one write port and one registered read port
// depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

module itfr_buf_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output      logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_idle_timeout_frame_receiver.sv @@
// tb_idle_timeout_frame_receiver: self-checking bench for the idle-timeout frame receiver,
// predicting every result word and comparing it under random idling and back-pressure
// depends on itfr_pkg and idle_timeout_frame_receiver
`timescale 1ns / 1ps

module tb_idle_timeout_frame_receiver;
  import itfr_pkg::*;

  localparam int BUF_DEPTH = 256;

  class frame_tracker #(int DEPTH = 256);
    logic [7:0]  stored [DEPTH];
    int unsigned length;
    bit          done;
    bit          running;
    int unsigned idle_ticks;
    logic [15:0] timeout;
    out_word_t   expected_words [$];
    int          mismatches;
    int          checked;
    int          closes;
    int          wraps;

    function new();
      length     = 0;
      done       = 1'b0;
      running    = 1'b0;
      idle_ticks = 0;
      timeout    = TIMEOUT_RESET;
      mismatches = 0;
      checked    = 0;
      closes     = 0;
      wraps      = 0;
    endfunction

    function void set_timeout(logic [15:0] value);
      timeout = value;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void take_word(in_word_t w);
      out_word_t  exp_word;
      logic [7:0] rdata;
      bit         was_done;
      rdata    = 8'd0;
      was_done = done;
      case (w.mode)
        MODE_RX_BYTE: begin
          if (length < DEPTH - 1) begin
            idle_ticks = 0;
            if (length == 0) running = 1'b1;
            stored[length] = w.rx_byte;
            length++;
          end else begin
            stored[0] = w.rx_byte;
            length    = 1;
            wraps++;
          end
        end
        MODE_TICK: begin
          if (running) begin
            if (idle_ticks < 32'hFFFF) idle_ticks++;
            if (idle_ticks >= timeout) begin
              done    = 1'b1;
              running = 1'b0;
            end
          end
        end
        MODE_RESTART: begin
          length = 0;
          done   = 1'b0;
        end
        MODE_READ: begin
          if (w.read_index < length && w.read_index < DEPTH) rdata = stored[w.read_index];
        end
      endcase
      if (done && !was_done) closes++;
      exp_word.frame_done   = done;
      exp_word.frame_length = done ? length[7:0] : 8'd0;
      exp_word.read_data    = rdata;
      expected_words.push_back(exp_word);
    endfunction

    task report(string msg);
      $display("[tb] mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task match_word(out_word_t got);
      out_word_t exp_word;
      if (expected_words.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        exp_word = expected_words.pop_front();
        checked++;
        if (got.frame_done !== exp_word.frame_done)
          report($sformatf("frame_done got %0b exp %0b", got.frame_done, exp_word.frame_done));
        if (got.frame_length !== exp_word.frame_length)
          report($sformatf("frame_length got %0d exp %0d", got.frame_length,
                           exp_word.frame_length));
        if (got.read_data !== exp_word.read_data)
          report($sformatf("read_data got %02h exp %02h", got.read_data, exp_word.read_data));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_word_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_word_t   out_data_o;

  frame_tracker #(BUF_DEPTH) tracker;
  int words_sent;
  int gap_pct;
  int stall_pct;
  bit long_hold_req;

  idle_timeout_frame_receiver #(
    .BUF_DEPTH(BUF_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver side: random stall bursts and one long hold on request
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (40) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold_req = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.match_word(out_data_o);
  end

  task send_word(input logic [1:0] mode, input logic [7:0] data_byte, input logic [7:0] index);
    in_word_t w;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    w.mode       = mode;
    w.rx_byte    = data_byte;
    w.read_index = index;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_word(w);
    words_sent++;
  endtask

  task send_read();
    int idx;
    if ($urandom_range(0, 3) == 0) idx = $urandom_range(0, 255);
    else idx = $urandom_range(0, tracker.length + 1);
    if (idx > 255) idx = 255;
    send_word(MODE_READ, 8'($urandom), 8'(idx));
  endtask

  task drain_results();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task write_timeout(input logic [15:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_timeout(value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task run_frame(input int n_bytes);
    int          ticks;
    logic [15:0] to;
    to = tracker.timeout;
    if ($urandom_range(0, 99) < 85) send_word(MODE_RESTART, 8'($urandom), 8'($urandom));
    repeat (n_bytes) begin
      send_word(MODE_RX_BYTE, 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 9) < 2) send_word(MODE_TICK, 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 9) == 0) send_read();
    end
    ticks = (to <= 8) ? to + $urandom_range(0, 2) : $urandom_range(0, 6);
    // frame left open now and then
    if ($urandom_range(0, 9) == 0) ticks = $urandom_range(0, 1);
    repeat (ticks) send_word(MODE_TICK, 8'($urandom), 8'($urandom));
    repeat ($urandom_range(1, 4)) send_read();
    if ($urandom_range(0, 4) == 0) send_word(MODE_RX_BYTE, 8'($urandom), 8'($urandom));
  endtask

  task run_phase(input logic [15:0] to, input int n_words, input bit quiet,
                 input bit with_hold, input bit with_wrap);
    int start;
    bit hold_done;
    write_timeout(to);
    start     = words_sent;
    hold_done = 1'b0;
    if (with_wrap) run_frame(258);
    while (words_sent - start < n_words) begin
      if (quiet) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (with_hold && !hold_done && words_sent - start > n_words / 2) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_word(2'($urandom), 8'($urandom), 8'($urandom));
      end else if ($urandom_range(0, 7) == 0) begin
        run_frame($urandom_range(13, 40));
      end else begin
        run_frame($urandom_range(1, 12));
      end
    end
  endtask

  initial begin
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 16'd0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    gap_pct       = 0;
    stall_pct     = 0;
    long_hold_req = 1'b0;
    words_sent    = 0;
    tracker       = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    write_timeout(16'd2);
    send_word(MODE_TICK, 8'hFF, 8'hFF);
    send_word(MODE_READ, 8'h00, 8'h00);
    send_word(MODE_RX_BYTE, 8'h00, 8'h00);
    send_word(MODE_RX_BYTE, 8'hFF, 8'hFF);
    send_word(MODE_RX_BYTE, 8'hA5, 8'h00);
    send_word(MODE_READ, 8'h00, 8'h00);
    send_word(MODE_READ, 8'h00, 8'h02);
    send_word(MODE_READ, 8'h00, 8'h03);
    send_word(MODE_READ, 8'h00, 8'hFF);
    send_word(MODE_TICK, 8'h00, 8'h00);
    send_word(MODE_TICK, 8'h00, 8'h00);
    send_word(MODE_RX_BYTE, 8'h5A, 8'h00);
    send_word(MODE_READ, 8'h00, 8'h03);
    send_word(MODE_TICK, 8'h00, 8'h00);
    send_word(MODE_RESTART, 8'h00, 8'h00);
    send_word(MODE_RX_BYTE, 8'h01, 8'h00);
    send_word(MODE_RESTART, 8'h00, 8'h00);
    send_word(MODE_TICK, 8'h00, 8'h00);
    send_word(MODE_TICK, 8'h00, 8'h00);
    // zero timeout behaves as one
    write_timeout(16'd0);
    send_word(MODE_RX_BYTE, 8'h80, 8'h00);
    send_word(MODE_TICK, 8'h00, 8'h00);
    send_word(MODE_READ, 8'h00, 8'h00);
    write_timeout(16'hFFFF);
    send_word(MODE_RESTART, 8'h00, 8'h00);
    send_word(MODE_RX_BYTE, 8'h7F, 8'h00);
    send_word(MODE_TICK, 8'h00, 8'h00);

    // random part
    run_phase(16'd1, 300, 1'b0, 1'b0, 1'b0);
    run_phase(16'd3, 300, 1'b0, 1'b1, 1'b1);
    run_phase(16'hFFFF, 250, 1'b0, 1'b0, 1'b0);
    run_phase(16'($urandom_range(2, 8)), 300, 1'b0, 1'b0, 1'b0);
    run_phase(TIMEOUT_RESET, 400, 1'b0, 1'b0, 1'b0);
    run_phase(16'd5, 300, 1'b1, 1'b0, 1'b0);

    drain_results();
    $display("[tb] %0d input words, %0d results checked, %0d frames closed, %0d buffer wraps",
             words_sent, tracker.checked, tracker.closes, tracker.wraps);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("[idle_timeout_frame_receiver] OK");
    end else begin
      $display("[idle_timeout_frame_receiver] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[idle_timeout_frame_receiver] ERROR");
    $finish;
  end

endmodule
